/* design/lde_pkg.sv */
`default_nettype none

package lde_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN
	} state_t;

	localparam logic [1:0] FUNC_SUBMIT  = 2'd0;
	localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
	localparam logic [1:0] FUNC_QUERY   = 2'd2;

	localparam logic [2:0] STAT_QUEUED    = 3'd0;
	localparam logic [2:0] STAT_LOST      = 3'd1;
	localparam logic [2:0] STAT_FULL      = 3'd2;
	localparam logic [2:0] STAT_DELIVERED = 3'd3;
	localparam logic [2:0] STAT_NONE_DUE  = 3'd4;
	localparam logic [2:0] STAT_QUERY     = 3'd5;

	localparam logic [1:0] REG_BYTE_TIME    = 2'd0;
	localparam logic [1:0] REG_LINK_LATENCY = 2'd1;
	localparam logic [1:0] REG_LOSS_PATTERN = 2'd2;

	localparam int TIME_BITS  = 64;
	localparam int LEN_BITS   = 11;
	localparam int COUNT_BITS = 32;
	localparam int BT_BITS    = 32;
	localparam int PROD_BITS  = BT_BITS + LEN_BITS;
	localparam int SER_SHIFT  = 20;

endpackage

`default_nettype wire

/* design/lde_fifo_mem.sv */
`default_nettype none

module lde_fifo_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-cycle write
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* design/link_delay_loss_emulator_core.sv */
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------------
// request   | in        | in_valid / in_stall  | func, now_time, packet_length, packet_tag
// result    | out       | out_valid / out_stall| status, out_tag, time_value,
//           |           |                      | sent_count, dropped_count
// config    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every request goes through these steps in order: capture plus multiply, the busy-time add and head
// compare, then the arrival add with state and FIFO memory update. The FIFO memory has one
// registered read port on the head slot; its latency sets the middle step.
// One request is in flight at a time; a result held by out_stall holds the final step.
// Reset clears control state and counters; FIFO memory contents are not cleared.
// cfg_ready is always high.

module link_delay_loss_emulator_core #(
	parameter int FIFO_DEPTH       = 64,
	parameter int MAX_PACKET_BYTES = 1536,
	parameter int TAG_BITS         = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      func,
	input  wire logic [lde_pkg::TIME_BITS-1:0]   now_time,
	input  wire logic [lde_pkg::LEN_BITS-1:0]    packet_length,
	input  wire logic [TAG_BITS-1:0]             packet_tag,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [2:0]                           status,
	output logic [TAG_BITS-1:0]                  out_tag,
	output logic [lde_pkg::TIME_BITS-1:0]        time_value,
	output logic [lde_pkg::COUNT_BITS-1:0]       sent_count,
	output logic [lde_pkg::COUNT_BITS-1:0]       dropped_count,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [63:0]                     cfg_data
);

	import lde_pkg::*;

	localparam int IdxW = $clog2(FIFO_DEPTH);
	localparam int CntW = $clog2(FIFO_DEPTH + 1);
	localparam int EntW = TAG_BITS + TIME_BITS;
	localparam logic [15:0] MaxLen = 16'(MAX_PACKET_BYTES);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(FIFO_DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(FIFO_DEPTH);
	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	state_t state_q, state_d;

	// configuration
	logic [BT_BITS-1:0]   byte_time_q;
	logic [31:0]          link_latency_q;
	logic [TIME_BITS-1:0] mask_q;

	// link and FIFO control state
	logic [TIME_BITS-1:0]  busy_q;
	logic [IdxW-1:0]       head_q, tail_q;
	logic [CntW-1:0]       fill_q;
	logic [COUNT_BITS-1:0] sent_q, dropped_q;

	// request captured at accept
	logic [1:0]           func_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [TAG_BITS-1:0]  tag_s1;
	logic [PROD_BITS-1:0] prod_s1;

	// second step
	logic [TIME_BITS-1:0] busy_sum_s2;
	logic [TIME_BITS-1:0] head_arr_s2;
	logic [TAG_BITS-1:0]  head_tag_s2;
	logic                 due_s2, earlier_s2;

	// result register
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [TAG_BITS-1:0]   out_tag_q;
	logic [TIME_BITS-1:0]  time_value_q;
	logic [COUNT_BITS-1:0] sent_count_q, dropped_count_q;

	logic in_accept, out_free, fin_go;

	logic [LEN_BITS-1:0] len_sat;
	logic [TIME_BITS-1:0] start_time;
	logic [PROD_BITS-SER_SHIFT-1:0] tx_raw;
	logic [TIME_BITS-1:0] tx_time;

	logic [EntW-1:0] rd_entry;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TIME_BITS-1:0] rd_arr;

	logic                  res_push, res_pop, res_link;
	logic                  res_lost;
	logic [2:0]            res_status;
	logic [TAG_BITS-1:0]   res_tag;
	logic [TIME_BITS-1:0]  res_time;
	logic [TIME_BITS-1:0]  arrival;
	logic [COUNT_BITS-1:0] sent_next, dropped_next;

	assign cfg_ready = 1'b1;

	// state machine: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_accept) state_d = ST_CALC;
			ST_CALC: state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state machine: outputs
	always_comb begin
		in_stall = 1'b1;
		fin_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_CALC: ;
			ST_FIN:  fin_go = out_free;
			default: ;
		endcase
	end

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	lde_fifo_mem #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (EntW)
	) u_mem (
		.clk     (clk),
		.wr_en   (fin_go && res_push),
		.wr_addr (tail_q),
		.wr_data ({tag_s1, arrival}),
		.rd_addr (head_q),
		.rd_data (rd_entry)
	);

	assign rd_tag = rd_entry[EntW-1:TIME_BITS];
	assign rd_arr = rd_entry[TIME_BITS-1:0];

	always_comb begin
		if ({5'd0, packet_length} > MaxLen) begin
			len_sat = MaxLen[LEN_BITS-1:0];
		end else begin
			len_sat = packet_length;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1 <= func;
			now_s1  <= now_time;
			tag_s1  <= packet_tag;
			prod_s1 <= PROD_BITS'(byte_time_q) * PROD_BITS'(len_sat);
		end
	end

	assign start_time = (now_s1 > busy_q) ? now_s1 : busy_q;
	assign tx_raw     = prod_s1[PROD_BITS-1:SER_SHIFT];
	assign tx_time    = (tx_raw == '0) ? TIME_BITS'(1)
	                                   : {{(TIME_BITS-PROD_BITS+SER_SHIFT){1'b0}}, tx_raw};

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			busy_sum_s2 <= start_time + tx_time;
			head_arr_s2 <= rd_arr;
			head_tag_s2 <= rd_tag;
			due_s2      <= (fill_q != '0) && (rd_arr <= now_s1);
			earlier_s2  <= (fill_q != '0) && (rd_arr < now_s1);
		end
	end

	assign arrival = busy_sum_s2 + {32'd0, link_latency_q};
	assign sent_next    = (sent_q == CountMax) ? sent_q : sent_q + 1'b1;
	assign dropped_next = (dropped_q == CountMax) ? dropped_q : dropped_q + 1'b1;

	// final step: result and state update
	always_comb begin
		res_push   = 1'b0;
		res_pop    = 1'b0;
		res_link   = 1'b0;
		res_lost   = 1'b0;
		res_status = STAT_QUERY;
		res_tag    = '0;
		res_time   = '0;
		case (func_s1)
			FUNC_SUBMIT: begin
				if (fill_q == FullCnt) begin
					res_status = STAT_FULL;
				end else begin
					res_link = 1'b1;
					if (mask_q[0]) begin
						res_lost   = 1'b1;
						res_status = STAT_LOST;
					end else begin
						res_push   = 1'b1;
						res_status = STAT_QUEUED;
						res_time   = arrival;
					end
				end
			end
			FUNC_DEQUEUE: begin
				if (due_s2) begin
					res_pop    = 1'b1;
					res_status = STAT_DELIVERED;
					res_tag    = head_tag_s2;
					res_time   = head_arr_s2;
				end else begin
					res_status = STAT_NONE_DUE;
				end
			end
			default: begin
				// unused code 3 answers as a query
				res_status = STAT_QUERY;
				res_time   = earlier_s2 ? head_arr_s2 : now_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_time_q    <= '0;
			link_latency_q <= '0;
			mask_q         <= '0;
			busy_q         <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			fill_q         <= '0;
			sent_q         <= '0;
			dropped_q      <= '0;
		end else begin
			if (fin_go) begin
				if (res_link) begin
					busy_q <= busy_sum_s2;
					mask_q <= {mask_q[0], mask_q[TIME_BITS-1:1]};
				end
				if (res_lost) begin
					dropped_q <= dropped_next;
				end
				if (res_push) begin
					tail_q <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
					fill_q <= fill_q + 1'b1;
					sent_q <= sent_next;
				end
				if (res_pop) begin
					head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
					fill_q <= fill_q - 1'b1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BYTE_TIME:    byte_time_q    <= cfg_data[BT_BITS-1:0];
					REG_LINK_LATENCY: link_latency_q <= cfg_data[31:0];
					REG_LOSS_PATTERN: mask_q         <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q        <= res_status;
			out_tag_q       <= res_tag;
			time_value_q    <= res_time;
			sent_count_q    <= res_push ? sent_next : sent_q;
			dropped_count_q <= res_lost ? dropped_next : dropped_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_tag       = out_tag_q;
	assign time_value    = time_value_q;
	assign sent_count    = sent_count_q;
	assign dropped_count = dropped_count_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FullCnt)
		else $error("fifo fill count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (head_q == tail_q))
		else $error("empty fifo with head and tail apart");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && res_pop) |-> (fill_q != '0))
		else $error("delivery from an empty fifo");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && res_push) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("queued request did not grow the fifo");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN))
		else $error("final step left while result register was held");

endmodule

`default_nettype wire
